// ----- rtl/core/pwp_pkg.sv -----
// Shared types and constants for the window pooling block.
`default_nettype none

package pwp_pkg;

    // Default sizing of the top level.
    localparam int DEF_MAX_CHANNELS = 64;
    localparam int DEF_MAX_WIDTH    = 64;
    localparam int DEF_MAX_HEIGHT   = 64;
    localparam int DEF_MAX_WINDOW   = 8;

    // Sample / result word.
    localparam int DATA_W = 16;

    // Configuration port.
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int DIM_W      = 7;
    localparam int WIN_W      = 4;
    localparam int MODE_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd5;

    localparam logic [DIM_W-1:0]  RST_CHANNELS = 7'd1;
    localparam logic [DIM_W-1:0]  RST_HEIGHT   = 7'd28;
    localparam logic [DIM_W-1:0]  RST_WIDTH    = 7'd28;
    localparam logic [WIN_W-1:0]  RST_WIN      = 4'd2;

    localparam logic [MODE_W-1:0] MODE_MEAN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_DIV,
        ST_EMIT
    } pwp_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic take;       // word accepted: latch sample, read store, step counters
        logic fold;       // combine with partial, write store
        logic div_start;  // launch divider on the folded sum
        logic load_out;   // move the result into the output register
    } pwp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic emit;       // folded word completes a window
        logic mean;       // mean mode selected
        logic div_done;   // divider finished
        logic out_free;   // output register can take a result
    } pwp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/pwp_div.sv -----
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module pwp_div #(
    parameter int ACC_W = 22,
    parameter int DIV_W = 7
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     start,
    input  wire signed [ACC_W-1:0]  dividend,
    input  wire        [DIV_W-1:0]  divisor,
    output logic                    done,
    output logic signed [pwp_pkg::DATA_W-1:0] quotient
);
    import pwp_pkg::*;

    localparam int CNT_W = $clog2(ACC_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic             neg_reg, neg_next;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   trial;
    logic [ACC_W-1:0] q_signed;

    always_comb begin
        shifted = {rem_reg, quo_reg[ACC_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ACC_W - 1);
            quo_next  = dividend[ACC_W-1] ? (~dividend + ACC_W'(1)) : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[ACC_W-1];
        end else if (busy_reg) begin
            if (!trial[DIV_W]) begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[ACC_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[ACC_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // mean of in-range samples always fits the result word
    assign q_signed = neg_reg ? (~quo_reg + ACC_W'(1)) : quo_reg;
    assign quotient = q_signed[DATA_W-1:0];
    assign done     = done_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pwp_dp.sv -----
// Datapath: config registers, position counters, partial store, fold and output register.
`default_nettype none

module pwp_dp #(
    parameter int MAX_CHANNELS = pwp_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_WIDTH    = pwp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = pwp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW   = pwp_pkg::DEF_MAX_WINDOW
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [pwp_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire  [pwp_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire  [pwp_pkg::DATA_W-1:0]         s_sample,
    input  wire  pwp_pkg::pwp_cmd_t            cmd,
    output pwp_pkg::pwp_sts_t                  sts,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [pwp_pkg::DATA_W-1:0]         m_pooled,
    output logic                               m_frame_end
);
    import pwp_pkg::*;

    localparam int ACC_W = DATA_W + $clog2(MAX_WINDOW * MAX_WINDOW);
    localparam int DIV_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1) > 0 ?
                           $clog2(MAX_WINDOW * MAX_WINDOW + 1) : 1;
    localparam int CHW   = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
    localparam int CLW   = MAX_WIDTH    > 1 ? $clog2(MAX_WIDTH)    : 1;
    localparam int RW    = MAX_HEIGHT   > 1 ? $clog2(MAX_HEIGHT)   : 1;
    localparam int WOW   = MAX_WINDOW   > 1 ? $clog2(MAX_WINDOW)   : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_HEIGHT + MAX_WIDTH + MAX_CHANNELS +
                                  2 * MAX_WINDOW + 256) + 1;

    // ---------------- configuration ----------------
    logic [DIM_W-1:0]  ch_reg, h_reg, w_reg;
    logic [WIN_W-1:0]  kx_reg, ky_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              restart;

    assign restart = cfg_wr_en && (cfg_addr <= REG_MODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg   <= RST_CHANNELS;
            h_reg    <= RST_HEIGHT;
            w_reg    <= RST_WIDTH;
            kx_reg   <= RST_WIN;
            ky_reg   <= RST_WIN;
            mode_reg <= MODE_MAX;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CHANNELS: ch_reg   <= cfg_wdata[DIM_W-1:0];
                REG_HEIGHT:   h_reg    <= cfg_wdata[DIM_W-1:0];
                REG_WIDTH:    w_reg    <= cfg_wdata[DIM_W-1:0];
                REG_WIN_X:    kx_reg   <= cfg_wdata[WIN_W-1:0];
                REG_WIN_Y:    ky_reg   <= cfg_wdata[WIN_W-1:0];
                REG_MODE:     mode_reg <= cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // zero reads as one, oversize reads as the limit
    logic [DIM_W-1:0] nch, h, w;
    logic [WIN_W-1:0] kx, ky;

    always_comb begin
        nch = (ch_reg == '0) ? DIM_W'(1) :
              (CW'(ch_reg) > CW'(MAX_CHANNELS)) ? DIM_W'(MAX_CHANNELS) : ch_reg;
        h   = (h_reg == '0) ? DIM_W'(1) :
              (CW'(h_reg) > CW'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_reg;
        w   = (w_reg == '0) ? DIM_W'(1) :
              (CW'(w_reg) > CW'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_reg;
        kx  = (kx_reg == '0) ? WIN_W'(1) :
              (CW'(kx_reg) > CW'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : kx_reg;
        ky  = (ky_reg == '0) ? WIN_W'(1) :
              (CW'(ky_reg) > CW'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : ky_reg;
    end

    logic [CW-1:0] nch_c, h_c, w_c, kx_c, ky_c;
    assign nch_c = CW'(nch);
    assign h_c   = CW'(h);
    assign w_c   = CW'(w);
    assign kx_c  = CW'(kx);
    assign ky_c  = CW'(ky);

    // ---------------- position counters ----------------
    logic [CHW-1:0] chan_reg, chan_next;
    logic [CLW-1:0] col_reg, col_next, cbase_reg, cbase_next, ocol_reg, ocol_next;
    logic [RW-1:0]  row_reg, row_next, rbase_reg, rbase_next;
    logic [WOW-1:0] wco_reg, wco_next, wro_reg, wro_next;

    logic chan_wrap, col_wrap, row_wrap, wco_wrap, wro_wrap;
    assign chan_wrap = CW'(chan_reg) + CW'(1) >= nch_c;
    assign col_wrap  = CW'(col_reg)  + CW'(1) >= w_c;
    assign row_wrap  = CW'(row_reg)  + CW'(1) >= h_c;
    assign wco_wrap  = CW'(wco_reg)  + CW'(1) >= kx_c;
    assign wro_wrap  = CW'(wro_reg)  + CW'(1) >= ky_c;

    always_comb begin
        chan_next  = chan_reg;
        col_next   = col_reg;
        cbase_next = cbase_reg;
        ocol_next  = ocol_reg;
        row_next   = row_reg;
        rbase_next = rbase_reg;
        wco_next   = wco_reg;
        wro_next   = wro_reg;
        if (restart) begin
            chan_next  = '0;
            col_next   = '0;
            cbase_next = '0;
            ocol_next  = '0;
            row_next   = '0;
            rbase_next = '0;
            wco_next   = '0;
            wro_next   = '0;
        end else if (cmd.take) begin
            if (!chan_wrap) begin
                chan_next = chan_reg + CHW'(1);
            end else begin
                chan_next = '0;
                if (col_wrap) begin
                    col_next   = '0;
                    cbase_next = '0;
                    ocol_next  = '0;
                    wco_next   = '0;
                    if (row_wrap) begin
                        row_next   = '0;
                        rbase_next = '0;
                        wro_next   = '0;
                    end else begin
                        row_next = row_reg + RW'(1);
                        if (wro_wrap) begin
                            wro_next   = '0;
                            rbase_next = row_reg + RW'(1);
                        end else begin
                            wro_next = wro_reg + WOW'(1);
                        end
                    end
                end else begin
                    col_next = col_reg + CLW'(1);
                    if (wco_wrap) begin
                        wco_next   = '0;
                        cbase_next = col_reg + CLW'(1);
                        ocol_next  = ocol_reg + CLW'(1);
                    end else begin
                        wco_next = wco_reg + WOW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg  <= '0;
            col_reg   <= '0;
            cbase_reg <= '0;
            ocol_reg  <= '0;
            row_reg   <= '0;
            rbase_reg <= '0;
            wco_reg   <= '0;
            wro_reg   <= '0;
        end else begin
            chan_reg  <= chan_next;
            col_reg   <= col_next;
            cbase_reg <= cbase_next;
            ocol_reg  <= ocol_next;
            row_reg   <= row_next;
            rbase_reg <= rbase_next;
            wco_reg   <= wco_next;
            wro_reg   <= wro_next;
        end
    end

    // ---------------- word classification ----------------
    logic          in_range, win_first, win_last, frame_last;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] rb_c, cb_c;

    assign rb_c       = CW'(rbase_reg);
    assign cb_c       = CW'(cbase_reg);
    // window must fit inside the map
    assign in_range   = (rb_c + ky_c <= h_c) && (cb_c + kx_c <= w_c);
    assign win_first  = (wro_reg == '0) && (wco_reg == '0);
    assign win_last   = wro_wrap && wco_wrap;
    // no further full window to the right / below
    assign frame_last = (rb_c + ky_c + ky_c > h_c) && (cb_c + kx_c + kx_c > w_c)
                        && chan_wrap;
    assign rd_addr    = AW'(int'(ocol_reg) * MAX_CHANNELS + int'(chan_reg));

    logic [DATA_W-1:0] samp_reg;
    logic [AW-1:0]     addr_reg;
    logic              inr_reg, first_reg, last_reg, frame_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            samp_reg  <= s_sample;
            addr_reg  <= rd_addr;
            inr_reg   <= in_range;
            first_reg <= win_first;
            last_reg  <= win_last;
            frame_reg <= frame_last;
        end
    end

    // ---------------- partial store ----------------
    logic [ACC_W-1:0] store_mem [DEPTH];
    logic [ACC_W-1:0] rd_reg;
    logic signed [ACC_W-1:0] acc_next;

    always_ff @(posedge aclk) begin
        if (cmd.fold && inr_reg) begin
            store_mem[addr_reg] <= acc_next;
        end
        if (cmd.take) begin
            rd_reg <= store_mem[rd_addr];
        end
    end

    // ---------------- fold ----------------
    logic signed [ACC_W-1:0] s_ext, part, folded;
    logic signed [ACC_W-1:0] acc_reg;

    assign s_ext = {{(ACC_W-DATA_W){samp_reg[DATA_W-1]}}, samp_reg};
    assign part  = rd_reg;

    always_comb begin
        case (mode_reg)
            MODE_MEAN: folded = part + s_ext;
            MODE_MIN:  folded = (s_ext < part) ? s_ext : part;
            MODE_MAX:  folded = (s_ext > part) ? s_ext : part;
            default:   folded = (s_ext > part) ? s_ext : part;
        endcase
        acc_next = first_reg ? s_ext : folded;
    end

    always_ff @(posedge aclk) begin
        if (cmd.fold) begin
            acc_reg <= acc_next;
        end
    end

    // ---------------- mean divider ----------------
    logic [DIV_W-1:0]         win_area;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_q;

    assign win_area = DIV_W'(DIV_W'(kx) * DIV_W'(ky));

    pwp_div #(
        .ACC_W (ACC_W),
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (acc_next),
        .divisor  (win_area),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------- output register ----------------
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (cmd.load_out) begin
            out_data_reg <= (mode_reg == MODE_MEAN) ? div_q : acc_reg[DATA_W-1:0];
            out_last_reg <= frame_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pooled    = out_data_reg;
    assign m_frame_end = out_last_reg;

    assign sts.emit     = inr_reg && last_reg;
    assign sts.mean     = (mode_reg == MODE_MEAN);
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || m_ready;

endmodule

`default_nettype wire

// ----- rtl/core/pwp_ctrl.sv -----
// Controller: sequences take, fold, divide and emit for one word at a time.
`default_nettype none

module pwp_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire pwp_pkg::pwp_sts_t  sts,
    output pwp_pkg::pwp_cmd_t       cmd
);
    import pwp_pkg::*;

    pwp_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_FOLD;
            end
            ST_FOLD: begin
                if (!sts.emit)     state_next = ST_IDLE;
                else if (sts.mean) state_next = ST_DIV;
                else               state_next = ST_EMIT;
            end
            ST_DIV: begin
                if (sts.div_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            ST_FOLD: begin
                cmd.fold      = 1'b1;
                cmd.div_start = sts.emit && sts.mean;
            end
            ST_DIV: ;
            ST_EMIT: begin
                cmd.load_out = sts.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/window_pooling_mean_min_max.sv -----
// Top level of the non-overlapping mean / min / max pooling block.
`default_nettype none

// Pools a streamed feature map (HWC order, channel fastest) over
// window_x by window_y windows whose stride equals the window. Each input
// word is one signed Q8.8 sample; each output word is one pooled Q8.8 value,
// emitted in output HWC order, with tlast marking the last value of the map.
// Mean is sum / (window_x*window_y) truncated toward zero; rows and columns
// that do not fill a whole window are swallowed without output.
// Throughput: one word at a time. A word that closes no window is taken and
// folded; a word that closes a min/max window is also emitted; a word that
// closes a mean window waits for the divider, which works on ACC_W = 16 +
// log2(MAX_WINDOW^2) bits. The pace is set by the read-modify-write of the
// partial store (one read, then at most one write per word) and by the
// bit-serial mean divider. Output backpressure stalls a word only while a
// previous result is still held. A config write to indexes 0 to 5 restarts
// the frame position; the partial store is not cleared (each window overwrites
// its entry with its first word), so there is no clearing pass after reset.
// Config: cfg_addr 0 channels, 1 map_height, 2 map_width, 3 window_x,
// 4 window_y, 5 pool_mode (0 mean, 1 min, 2/3 max); other indexes ignored.
// Write config only while the block is idle.
module window_pooling_mean_min_max #(
    parameter int MAX_CHANNELS = pwp_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_WIDTH    = pwp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = pwp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW   = pwp_pkg::DEF_MAX_WINDOW
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // config write port
    input  wire                              cfg_wr_en,
    input  wire  [pwp_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire  [pwp_pkg::CFG_W-1:0]        cfg_wdata,
    // sample stream
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [pwp_pkg::DATA_W-1:0]       s_axis_tdata,   // [15:0] sample
    // pooled stream
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [pwp_pkg::DATA_W-1:0]       m_axis_tdata,   // [15:0] pooled
    output logic                             m_axis_tlast    // frame_end
);
    import pwp_pkg::*;

    pwp_cmd_t cmd;
    pwp_sts_t sts;

    // FSM: idle -> fold -> (div) -> emit, or fold -> idle when no window closes
    pwp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // counters, partial store, fold, divider, output register
    pwp_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_sample    (s_axis_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_pooled    (m_axis_tdata),
        .m_frame_end (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/core/pwp_checker.sv -----
// Port-level checks for the pooling block, bound to the top level.
`default_nettype none

module pwp_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire        m_axis_tlast
);

    // output register is empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("m_axis_tvalid set after reset");

    // one word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // a result is loaded only while input is held off
    a_load_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while idle");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

endmodule

bind window_pooling_mean_min_max pwp_checker u_pwp_checker (.*);

`default_nettype wire
